/* design/torus_route_hint_fifo_select_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef TORUS_ROUTE_HINT_FIFO_SELECT_ASSERT_SVH
`define TORUS_ROUTE_HINT_FIFO_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TRHFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("torus route hint fifo select: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TRHFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("torus route hint fifo select: assertion failed");

`endif

/* design/trhfs_pkg.sv */
package trhfs_pkg;

  localparam int NUM_FIFOS = 8;
  localparam int FIFO_IDX_W = 3;
  localparam int FILL_W = 6;
  localparam int HINT_W = 6;
  localparam int CRD_W = 8;
  localparam int CUTOFF_W = 24;
  localparam int CFG_IDX_W = 3;

  // Only the two priority fifos for high-priority packets, else the six normal ones.
  localparam logic [NUM_FIFOS-1:0] MASK_HIGH = 8'h03;
  localparam logic [NUM_FIFOS-1:0] MASK_NORMAL = 8'hFC;

  typedef enum logic {
    ACT_ROUTE = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_X = 3'd0,
    REG_NODE_Y = 3'd1,
    REG_NODE_Z = 3'd2,
    REG_CUTOFF_PLUS = 3'd3,
    REG_CUTOFF_MINUS = 3'd4
  } reg_index_t;

  typedef struct packed {
    action_t action;
    logic [CRD_W-1:0] dest_x;
    logic [CRD_W-1:0] dest_y;
    logic [CRD_W-1:0] dest_z;
    logic [HINT_W-1:0] preset_hints;
    logic high_priority;
    logic [2:0] chunk_field;
    logic [FIFO_IDX_W-1:0] fifo_index;
    logic [FILL_W-1:0] fill_level;
  } req_item_t;

  typedef struct packed {
    logic [HINT_W-1:0] hint_bits;
    logic [NUM_FIFOS-1:0] eligible_mask;
    logic [FIFO_IDX_W-1:0] chosen_fifo;
    logic fifo_found;
  } rsp_item_t;

  typedef struct packed {
    logic [CRD_W-1:0] node_x;
    logic [CRD_W-1:0] node_y;
    logic [CRD_W-1:0] node_z;
    logic [CUTOFF_W-1:0] cutoff_plus;
    logic [CUTOFF_W-1:0] cutoff_minus;
  } cfg_regs_t;

endpackage

/* design/torus_route_hint_fifo_select.sv */
// Picks a torus injection fifo for each route transaction and keeps the fill levels of the
// eight fifos from update transactions. One request is accepted every clock cycle while the
// request side is not stalled; a route request is held in the request register, where hint,
// eligibility and first-fit selection are worked out, and its response is loaded into the
// response register once that register is empty or unstalled. Update requests take effect
// when they leave the request register and produce no response; a route request behind an
// update already sees the new fill level. A stalled response stalls the request side in the
// same cycle while a route request is held. Configuration writes are always ready.
module torus_route_hint_fifo_select
  import trhfs_pkg::*;
#(
  parameter int FIFO_CAPACITY = 32,
  parameter int COORD_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_item_t            req_item,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_item_t            rsp_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CUTOFF_W-1:0]  cfg_data
);

  cfg_regs_t                        regs;
  logic                             held_valid;
  req_item_t                        held;
  logic [NUM_FIFOS-1:0][FILL_W-1:0] fifo_fill;
  rsp_item_t                        result;
  logic                             advance;
  logic                             load_rsp;

  trhfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  trhfs_route #(
    .FIFO_CAPACITY (FIFO_CAPACITY),
    .COORD_BITS    (COORD_BITS)
  ) u_route (
    .item   (held),
    .regs   (regs),
    .fill   (fifo_fill),
    .result (result)
  );

  // An update never needs the response register, so it moves on even under stall.
  assign advance = held_valid &&
                   (held.action == ACT_UPDATE || !rsp_valid || !rsp_stall);
  assign load_rsp = advance && held.action == ACT_ROUTE;
  assign req_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= req_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_fill <= '0;
    end else if (advance && held.action == ACT_UPDATE) begin
      fifo_fill[held.fifo_index] <= held.fill_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_item <= result;
    end
  end

endmodule

/* design/trhfs_cfg.sv */
module trhfs_cfg
  import trhfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CUTOFF_W-1:0]  cfg_data,
  output cfg_regs_t            regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.node_x <= '0;
      regs.node_y <= '0;
      regs.node_z <= '0;
      regs.cutoff_plus <= '1;
      regs.cutoff_minus <= '0;
    end else if (cfg_valid) begin
      // Indexes past the last register are dropped.
      unique case (cfg_index)
        REG_NODE_X: regs.node_x <= cfg_data[CRD_W-1:0];
        REG_NODE_Y: regs.node_y <= cfg_data[CRD_W-1:0];
        REG_NODE_Z: regs.node_z <= cfg_data[CRD_W-1:0];
        REG_CUTOFF_PLUS: regs.cutoff_plus <= cfg_data;
        REG_CUTOFF_MINUS: regs.cutoff_minus <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/trhfs_route.sv */
module trhfs_route
  import trhfs_pkg::*;
#(
  parameter int FIFO_CAPACITY = 32,
  parameter int COORD_BITS = 8
) (
  input  req_item_t                           item,
  input  cfg_regs_t                           regs,
  input  logic [NUM_FIFOS-1:0][FILL_W-1:0]    fill,
  output rsp_item_t                           result
);

  localparam int SUM_W = FILL_W + 1;
  localparam logic [SUM_W-1:0] CAP = SUM_W'(FIFO_CAPACITY);
  localparam logic [1:0] HINT_NONE = 2'b00;
  localparam logic [1:0] HINT_PLUS = 2'b01;
  localparam logic [1:0] HINT_MINUS = 2'b10;

  function automatic logic [1:0] axis_hint(input logic [COORD_BITS-1:0] here,
                                           input logic [COORD_BITS-1:0] dest,
                                           input logic [COORD_BITS-1:0] cp,
                                           input logic [COORD_BITS-1:0] cm);
    logic [1:0] h;
    if (here < dest) begin
      h = (dest <= cp) ? HINT_PLUS : HINT_MINUS;
    end else if (here > dest) begin
      h = (dest >= cm) ? HINT_MINUS : HINT_PLUS;
    end else begin
      h = HINT_NONE;
    end
    return h;
  endfunction

  logic [HINT_W-1:0]    computed;
  logic [HINT_W-1:0]    hints;
  logic [NUM_FIFOS-1:0] mask;
  logic [SUM_W-1:0]     chunks;
  logic [FIFO_IDX_W-1:0] chosen;
  logic                 found;

  always_comb begin
    computed[1:0] = axis_hint(regs.node_x[COORD_BITS-1:0], item.dest_x[COORD_BITS-1:0],
                              regs.cutoff_plus[COORD_BITS-1:0],
                              regs.cutoff_minus[COORD_BITS-1:0]);
    computed[3:2] = axis_hint(regs.node_y[COORD_BITS-1:0], item.dest_y[COORD_BITS-1:0],
                              regs.cutoff_plus[8 +: COORD_BITS],
                              regs.cutoff_minus[8 +: COORD_BITS]);
    computed[5:4] = axis_hint(regs.node_z[COORD_BITS-1:0], item.dest_z[COORD_BITS-1:0],
                              regs.cutoff_plus[16 +: COORD_BITS],
                              regs.cutoff_minus[16 +: COORD_BITS]);
    hints = (item.preset_hints == '0) ? computed : item.preset_hints;
  end

  always_comb begin
    priority if (item.high_priority) begin
      mask = MASK_HIGH;
    end else if (hints == '0) begin
      mask = MASK_NORMAL;
    end else begin
      mask = {hints, 2'b00};
    end
  end

  // Scan from the top down so that the lowest eligible fifo with room wins.
  always_comb begin
    chunks = SUM_W'(item.chunk_field) + SUM_W'(1);
    chosen = '0;
    found = 1'b0;
    for (int i = NUM_FIFOS - 1; i >= 0; i--) begin
      if (mask[i] && ({1'b0, fill[i]} + chunks <= CAP)) begin
        chosen = FIFO_IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign result.hint_bits = hints;
  assign result.eligible_mask = mask;
  assign result.chosen_fifo = chosen;
  assign result.fifo_found = found;

endmodule

/* design/trhfs_checker.sv */
`include "torus_route_hint_fifo_select_assert.svh"

module trhfs_checker
  import trhfs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp_item
);

  // A miss always reports fifo zero.
  `TRHFS_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_item.fifo_found, rsp_item.chosen_fifo == '0)

  // A chosen fifo must be one of the eligible ones.
  `TRHFS_ASSERT_NOW(a_chosen_eligible, rsp_valid && rsp_item.fifo_found, rsp_item.eligible_mask[rsp_item.chosen_fifo])

  // Normal packets with hints use exactly the fifos their hints name.
  `TRHFS_ASSERT_NOW(a_mask_from_hints, rsp_valid && rsp_item.eligible_mask != MASK_HIGH && rsp_item.hint_bits != '0, rsp_item.eligible_mask == {rsp_item.hint_bits, 2'b00})

  // A stalled response transaction is held unchanged.
  `TRHFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

endmodule

bind torus_route_hint_fifo_select trhfs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

/* tb/testbench.sv */
module testbench;
  import trhfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIFO_CAP = 32;
  localparam int NUM_PHASES = 9;
  localparam int ROUTES_PER_PHASE = 130;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CUTOFF_W-1:0] cfg_data = '0;

  req_item_t pending[$];
  rsp_item_t route_expect[$];
  cfg_regs_t cfg_model;
  logic [FILL_W-1:0] fill_model[NUM_FIFOS];

  logic req_taken = 1'b0;
  logic calm = 1'b0;
  int send_gap = 0;
  int rsp_run = 0;
  logic rsp_hold = 1'b0;
  int cycles = 0;
  int errors = 0;
  int n_route = 0;
  int n_update = 0;
  int n_found = 0;
  int n_full = 0;
  int n_cfg = 0;

  torus_route_hint_fifo_select DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item(req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item(rsp_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Direction for one axis: bit 0 plus, bit 1 minus, none when already there.
  function automatic logic [1:0] axis_dir(logic [CRD_W-1:0] here, logic [CRD_W-1:0] dest,
                                          logic [CRD_W-1:0] cut_p, logic [CRD_W-1:0] cut_m);
    if (dest > here) return (dest <= cut_p) ? 2'b01 : 2'b10;
    if (dest < here) return (dest >= cut_m) ? 2'b10 : 2'b01;
    return 2'b00;
  endfunction

  function automatic rsp_item_t predict_route(req_item_t r);
    rsp_item_t res;
    logic [HINT_W-1:0] hints;
    logic [NUM_FIFOS-1:0] mask;
    hints = r.preset_hints;
    if (hints == '0) begin
      hints = {axis_dir(cfg_model.node_z, r.dest_z, cfg_model.cutoff_plus[23:16],
                        cfg_model.cutoff_minus[23:16]),
               axis_dir(cfg_model.node_y, r.dest_y, cfg_model.cutoff_plus[15:8],
                        cfg_model.cutoff_minus[15:8]),
               axis_dir(cfg_model.node_x, r.dest_x, cfg_model.cutoff_plus[7:0],
                        cfg_model.cutoff_minus[7:0])};
    end
    if (r.high_priority) mask = MASK_HIGH;
    else if (hints == '0) mask = MASK_NORMAL;
    else mask = {hints, 2'b00};
    res.hint_bits = hints;
    res.eligible_mask = mask;
    res.chosen_fifo = '0;
    res.fifo_found = 1'b0;
    for (int i = 0; i < NUM_FIFOS; i++) begin
      if (!res.fifo_found && mask[i] &&
          int'(fill_model[i]) + int'(r.chunk_field) + 1 <= FIFO_CAP) begin
        res.chosen_fifo = FIFO_IDX_W'(i);
        res.fifo_found = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic req_item_t route_req(logic [CRD_W-1:0] dx, logic [CRD_W-1:0] dy,
                                          logic [CRD_W-1:0] dz, logic [HINT_W-1:0] hints,
                                          logic hp, logic [2:0] chunk);
    req_item_t r;
    r = '0;
    r.action = ACT_ROUTE;
    r.dest_x = dx;
    r.dest_y = dy;
    r.dest_z = dz;
    r.preset_hints = hints;
    r.high_priority = hp;
    r.chunk_field = chunk;
    return r;
  endfunction

  function automatic req_item_t fill_req(logic [FIFO_IDX_W-1:0] idx, logic [FILL_W-1:0] level);
    req_item_t r;
    r = '0;
    r.action = ACT_UPDATE;
    r.fifo_index = idx;
    r.fill_level = level;
    return r;
  endfunction

  // Destinations cluster around this node and the cutoffs, where the hint rules turn.
  function automatic logic [CRD_W-1:0] pick_coord(logic [CRD_W-1:0] here,
                                                  logic [CRD_W-1:0] cut_p,
                                                  logic [CRD_W-1:0] cut_m);
    case ($urandom_range(9))
      0: return here;
      1: return here + 8'd1;
      2: return here - 8'd1;
      3: return cut_p;
      4: return cut_p + 8'd1;
      5: return cut_m;
      6: return cut_m - 8'd1;
      7: return 8'h00;
      8: return 8'hFF;
      default: return CRD_W'($urandom);
    endcase
  endfunction

  function automatic req_item_t random_req();
    req_item_t r;
    int pick;
    r.action = ($urandom_range(9) < 3) ? ACT_UPDATE : ACT_ROUTE;
    r.dest_x = pick_coord(cfg_model.node_x, cfg_model.cutoff_plus[7:0],
                          cfg_model.cutoff_minus[7:0]);
    r.dest_y = pick_coord(cfg_model.node_y, cfg_model.cutoff_plus[15:8],
                          cfg_model.cutoff_minus[15:8]);
    r.dest_z = pick_coord(cfg_model.node_z, cfg_model.cutoff_plus[23:16],
                          cfg_model.cutoff_minus[23:16]);
    r.preset_hints = ($urandom_range(9) < 6) ? '0 : HINT_W'($urandom);
    r.high_priority = ($urandom_range(6) == 0);
    r.chunk_field = 3'($urandom);
    r.fifo_index = FIFO_IDX_W'($urandom);
    pick = $urandom_range(9);
    if (pick == 0) r.fill_level = FILL_W'($urandom_range(63, 33));
    else if (pick < 5) r.fill_level = FILL_W'($urandom_range(32, 24));
    else r.fill_level = FILL_W'($urandom_range(23));
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  always @(negedge clk) begin
    if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        req_item <= pending.pop_front();
        req_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rsp_run == 0) begin
      rsp_hold = !calm && ($urandom_range(2) == 0);
      rsp_run = rsp_hold ? pick_gap() + 1 : $urandom_range(8, 1);
    end
    rsp_run--;
    rsp_stall <= rsp_hold;
  end

  task automatic flag_field(string name, logic [7:0] want, logic [7:0] got);
    $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          REG_NODE_X: cfg_model.node_x = cfg_data[CRD_W-1:0];
          REG_NODE_Y: cfg_model.node_y = cfg_data[CRD_W-1:0];
          REG_NODE_Z: cfg_model.node_z = cfg_data[CRD_W-1:0];
          REG_CUTOFF_PLUS: cfg_model.cutoff_plus = cfg_data;
          REG_CUTOFF_MINUS: cfg_model.cutoff_minus = cfg_data;
          default: ;
        endcase
      end
      // The response leaving now belongs to an older request than any accepted this edge.
      if (rsp_valid && !rsp_stall) begin
        if (route_expect.size() == 0) begin
          $display("%0t ns: unexpected response transaction, expected none, got %h",
                   $time, rsp_item);
          errors++;
        end else begin
          want = route_expect.pop_front();
          if (want.fifo_found) n_found++;
          else n_full++;
          if (rsp_item.hint_bits !== want.hint_bits)
            flag_field("hint_bits", 8'(want.hint_bits), 8'(rsp_item.hint_bits));
          if (rsp_item.eligible_mask !== want.eligible_mask)
            flag_field("eligible_mask", want.eligible_mask, rsp_item.eligible_mask);
          if (rsp_item.chosen_fifo !== want.chosen_fifo)
            flag_field("chosen_fifo", 8'(want.chosen_fifo), 8'(rsp_item.chosen_fifo));
          if (rsp_item.fifo_found !== want.fifo_found)
            flag_field("fifo_found", 8'(want.fifo_found), 8'(rsp_item.fifo_found));
        end
      end
      if (req_valid && !req_stall) begin
        if (req_item.action == ACT_UPDATE) begin
          fill_model[req_item.fifo_index] = req_item.fill_level;
          n_update++;
        end else begin
          route_expect.push_back(predict_route(req_item));
          n_route++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t ns: run did not finish in time", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CUTOFF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [CRD_W-1:0] nx, logic [CRD_W-1:0] ny, logic [CRD_W-1:0] nz,
                           logic [CUTOFF_W-1:0] cut_p, logic [CUTOFF_W-1:0] cut_m,
                           logic poke_unused);
    write_reg(REG_NODE_X, {16'($urandom), nx});
    write_reg(REG_NODE_Y, {16'($urandom), ny});
    write_reg(REG_NODE_Z, {16'($urandom), nz});
    write_reg(REG_CUTOFF_PLUS, cut_p);
    write_reg(REG_CUTOFF_MINUS, cut_m);
    if (poke_unused)
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), CUTOFF_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds off until every transaction has left the block, update ones included.
  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || req_valid || route_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CRD_W-1:0] nx, ny, nz;
    cfg_model.node_x = '0;
    cfg_model.node_y = '0;
    cfg_model.node_z = '0;
    cfg_model.cutoff_plus = 24'hFFFFFF;
    cfg_model.cutoff_minus = '0;
    for (int i = 0; i < NUM_FIFOS; i++) fill_model[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: node in the middle on X, at the low end on Y, at the top on Z.
    configure(8'd128, 8'd0, 8'd255, 24'hFF80C0, 24'h000040, 1'b1);
    pending.push_back(route_req(8'd128, 8'd0, 8'd255, 6'h00, 1'b0, 3'd0));
    pending.push_back(route_req(8'd192, 8'd1, 8'd0, 6'h00, 1'b0, 3'd7));
    pending.push_back(route_req(8'd193, 8'd200, 8'd254, 6'h00, 1'b0, 3'd3));
    pending.push_back(route_req(8'd64, 8'd128, 8'd255, 6'h00, 1'b0, 3'd1));
    pending.push_back(route_req(8'd63, 8'd255, 8'd0, 6'h00, 1'b1, 3'd7));
    pending.push_back(route_req(8'd255, 8'd255, 8'd255, 6'h3F, 1'b0, 3'd0));
    pending.push_back(route_req(8'd0, 8'd0, 8'd0, 6'h01, 1'b0, 3'd5));
    for (int i = 0; i < NUM_FIFOS; i++)
      pending.push_back(fill_req(FIFO_IDX_W'(i), 6'd32));
    pending.push_back(route_req(8'd10, 8'd20, 8'd30, 6'h00, 1'b0, 3'd0));
    pending.push_back(route_req(8'd10, 8'd20, 8'd30, 6'h00, 1'b1, 3'd0));
    pending.push_back(fill_req(3'd1, 6'd24));
    pending.push_back(fill_req(3'd0, 6'd63));
    pending.push_back(route_req(8'd0, 8'd0, 8'd0, 6'h00, 1'b1, 3'd7));
    pending.push_back(fill_req(3'd7, 6'd0));
    pending.push_back(route_req(8'd128, 8'd0, 8'd255, 6'h20, 1'b0, 3'd7));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      nx = CRD_W'($urandom);
      ny = CRD_W'($urandom);
      nz = CRD_W'($urandom);
      calm = (ph == 6);
      case (ph)
        0: configure(8'd0, 8'd0, 8'd0, 24'hFFFFFF, 24'h000000, 1'b0);
        1: configure(8'd255, 8'd255, 8'd255, 24'h000000, 24'hFFFFFF, 1'b1);
        2: configure(8'd0, 8'd0, 8'd0, 24'h000000, 24'h000000, 1'b0);
        3: configure(8'd255, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        // Cutoffs at this node's own coordinates.
        8: configure(nx, ny, nz, {nz, ny, nx}, {nz, ny, nx}, 1'b1);
        default: configure(nx, ny, nz, CUTOFF_W'($urandom), CUTOFF_W'($urandom), ph[0]);
      endcase
      for (int k = 0; k < ROUTES_PER_PHASE; k++) pending.push_back(random_req());
      drain();
    end

    $display("Ran %0d route and %0d fill-update transactions over %0d register writes,",
             n_route, n_update, n_cfg);
    $display("under %0d node and cutoff settings; %0d routes found a fifo, %0d found none.",
             NUM_PHASES + 1, n_found, n_full);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
